FILE: hdl/sg_pkg.sv
// Shared types and constants for the Sobel gradient stream.
// Used by sg_front, sg_back and sobel_gradient_stream; depends on nothing.
package sg_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int HEIGHT_LIMIT    = 4096;
    localparam int WIDTH_CFG_W     = 9;
    localparam int HEIGHT_CFG_W    = 13;
    localparam int CFG_DATA_W      = 13;
    localparam int ROW_W           = 12;
    localparam int PIX_W           = 8;
    localparam int QUEUE_DEPTH     = 4;
    localparam int WIDTH_RST       = 256;
    localparam int HEIGHT_RST      = 256;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic produce;
        logic last_of_row;
        logic last_of_frame;
    } t_pix_tag;

    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } t_back_status;

endpackage

FILE: hdl/sg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/sg_front.sv
// Front end: input transfer, configuration registers, column/row counters
// and classification of each pixel. Depends on sg_pkg.
module sg_front #(
    parameter int MAX_WIDTH = sg_pkg::DEF_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sg_pkg::PIX_W-1:0]        i_pixel,
    input  logic                            i_start_of_frame,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [sg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                            i_full,
    output logic                            o_push,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_col,
    output logic [sg_pkg::PIX_W-1:0]        o_pix,
    output sg_pkg::t_pix_tag                o_tag
);
    import sg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int W_EFF_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    logic [CW-1:0]           r_w_last;
    logic [ROW_W-1:0]        r_h_last;
    logic [CW-1:0]           r_col;
    logic [ROW_W-1:0]        r_row;
    logic [CW-1:0]           n_col;
    logic [ROW_W-1:0]        n_row;
    logic [CW-1:0]           col;
    logic [ROW_W-1:0]        row;
    logic [WIDTH_CFG_W-1:0]  wcfg;
    logic [HEIGHT_CFG_W-1:0] hcfg;
    logic [CW-1:0]           w_last_cfg;
    logic [ROW_W-1:0]        h_last_cfg;
    logic                    accept;

    assign wcfg = i_cfg_data[WIDTH_CFG_W-1:0];
    assign hcfg = i_cfg_data[HEIGHT_CFG_W-1:0];

    always_comb begin
        if (wcfg < WIDTH_CFG_W'(3)) begin
            w_last_cfg = CW'(2);
        end else if (32'(wcfg) > MAX_WIDTH) begin
            w_last_cfg = CW'(MAX_WIDTH - 1);
        end else begin
            w_last_cfg = CW'(wcfg - WIDTH_CFG_W'(1));
        end
        if (hcfg < HEIGHT_CFG_W'(3)) begin
            h_last_cfg = ROW_W'(2);
        end else if (32'(hcfg) > HEIGHT_LIMIT) begin
            h_last_cfg = ROW_W'(HEIGHT_LIMIT - 1);
        end else begin
            h_last_cfg = ROW_W'(hcfg - HEIGHT_CFG_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(W_EFF_RST - 1);
            r_h_last <= ROW_W'(HEIGHT_RST - 1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    r_w_last <= w_last_cfg;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_h_last <= h_last_cfg;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        col = i_start_of_frame ? '0 : r_col;
        row = i_start_of_frame ? '0 : r_row;
        n_col = col + CW'(1);
        n_row = row;
        if (col >= r_w_last) begin
            n_col = '0;
            n_row = (row >= r_h_last) ? '0 : row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_push              = accept;
    assign o_col               = col;
    assign o_pix               = i_pixel;
    assign o_tag.produce       = (col >= CW'(2)) && (row >= ROW_W'(2));
    assign o_tag.last_of_row   = (col == r_w_last);
    assign o_tag.last_of_frame = (col == r_w_last) && (row == r_h_last);
endmodule

FILE: hdl/sg_queue.sv
// Small register queue between the front end and the back end.
// No dependencies; depth must be a power of two.
module sg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [AW:0]      r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end
endmodule

FILE: hdl/sg_back.sv
// Back end: line store access, 3x3 window, gradient datapath and output register.
// Depends on sg_pkg and sg_ram.
module sg_back #(
    parameter int MAX_WIDTH = sg_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_col,
    input  logic [sg_pkg::PIX_W-1:0]      i_pix,
    input  sg_pkg::t_pix_tag              i_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sg_pkg::PIX_W-1:0]      o_gradient,
    output logic                          o_last_of_row,
    output logic                          o_last_of_frame,
    output sg_pkg::t_back_status          o_status
);
    import sg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int GW = PIX_W + 2;

    // stage 1: item whose line store read is in flight
    logic                 r_s1_valid;
    logic [CW-1:0]        r_s1_col;
    logic [PIX_W-1:0]     r_s1_pix;
    t_pix_tag             r_s1_tag;
    logic                 r_byp;
    logic [2*PIX_W-1:0]   r_byp_data;
    logic [PIX_W-1:0]     r_win [6];

    // stage 2: signed gradients
    logic                 r_s2_valid;
    logic signed [GW-1:0] r_s2_gx;
    logic signed [GW-1:0] r_s2_gy;
    logic                 r_s2_lor;
    logic                 r_s2_lof;

    // output register
    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_out_grad;
    logic                 r_out_lor;
    logic                 r_out_lof;

    logic                 out_free;
    logic                 s2_free;
    logic                 s1_free;
    logic                 s1_adv;
    logic                 pop;
    logic [2*PIX_W-1:0]   ram_rdata;
    logic [PIX_W-1:0]     top;
    logic [PIX_W-1:0]     mid;
    logic [GW-1:0]        pos_x;
    logic [GW-1:0]        neg_x;
    logic [GW-1:0]        pos_y;
    logic [GW-1:0]        neg_y;
    logic signed [GW-1:0] gx;
    logic signed [GW-1:0] gy;
    logic [GW-1:0]        ax;
    logic [GW-1:0]        ay;
    logic [PIX_W-1:0]     grad;

    assign out_free = !r_out_valid || i_out_ready;
    assign s2_free  = !r_s2_valid || out_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign s1_adv   = r_s1_valid && s2_free;
    assign pop      = !i_empty && s1_free;
    assign o_pop    = pop;

    // entry holds {older row, newer row}
    sg_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata ({mid, r_s1_pix}),
        .i_re    (pop),
        .i_raddr (i_col),
        .o_rdata (ram_rdata)
    );

    assign {top, mid} = r_byp ? r_byp_data : ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (pop) begin
                r_s1_valid <= 1'b1;
                r_byp      <= s1_adv && (i_col == r_s1_col);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_col   <= i_col;
            r_s1_pix   <= i_pix;
            r_s1_tag   <= i_tag;
            r_byp_data <= {mid, r_s1_pix};
        end
    end

    // window: 0..2 = column c-2, 3..5 = column c-1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r_s1_pix;
        end
    end

    always_comb begin
        pos_x = GW'(top >> 2) + GW'(mid >> 1) + GW'(r_s1_pix >> 2);
        neg_x = GW'(r_win[0] >> 2) + GW'(r_win[1] >> 1) + GW'(r_win[2] >> 2);
        pos_y = GW'(r_win[2] >> 2) + GW'(r_win[5] >> 1) + GW'(r_s1_pix >> 2);
        neg_y = GW'(r_win[0] >> 2) + GW'(r_win[3] >> 1) + GW'(top >> 2);
        gx    = signed'(pos_x - neg_x);
        gy    = signed'(pos_y - neg_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= s1_adv && r_s1_tag.produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_s2_gx  <= gx;
            r_s2_gy  <= gy;
            r_s2_lor <= r_s1_tag.last_of_row;
            r_s2_lof <= r_s1_tag.last_of_frame;
        end
    end

    always_comb begin
        ax   = r_s2_gx[GW-1] ? GW'(-r_s2_gx) : GW'(r_s2_gx);
        ay   = r_s2_gy[GW-1] ? GW'(-r_s2_gy) : GW'(r_s2_gy);
        grad = ax[PIX_W:1] + ay[PIX_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_grad <= grad;
            r_out_lor  <= r_s2_lor;
            r_out_lof  <= r_s2_lof;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_gradient         = r_out_grad;
    assign o_last_of_row      = r_out_lor;
    assign o_last_of_frame    = r_out_lof;
    assign o_status.s1_valid  = r_s1_valid;
    assign o_status.s2_valid  = r_s2_valid;
endmodule

FILE: hdl/sobel_gradient_stream.sv
// Top level of the streaming 3x3 Sobel gradient block.
// Depends on sg_pkg, sg_front, sg_queue, sg_back and sg_ram.

// Accepts one 8-bit pixel per clock in raster order while the queue is not
// full and returns one gradient for every pixel at row >= 2 and column >= 2
// via the queue, stage 1, stage 2 and output register. The rate of one pixel
// per clock is set by the single-port-read line store (one 16-bit entry per
// column holding the two previous rows) that is read once and written once
// per pixel. A four-entry queue separates the input counters from the
// datapath, so the input side keeps taking pixels while a result waits on
// the output until the queue fills. Line store entries hold garbage after
// reset until their column has been seen; there is no clearing pass.
// Writes clamp image_width and image_height to 3..MAX_WIDTH and 3..4096.
module sobel_gradient_stream #(
    parameter int MAX_WIDTH = sg_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sg_pkg::PIX_W-1:0]      i_pixel,
    input  logic                          i_start_of_frame,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sg_pkg::PIX_W-1:0]      o_gradient,
    output logic                          o_last_of_row,
    output logic                          o_last_of_frame,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [sg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = CW + PIX_W + $bits(t_pix_tag);

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    logic [CW-1:0]  f_col;
    logic [PIX_W-1:0] f_pix;
    t_pix_tag       f_tag;
    logic [CW-1:0]  b_col;
    logic [PIX_W-1:0] b_pix;
    t_pix_tag       b_tag;
    t_back_status   status;

    sg_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pixel          (i_pixel),
        .i_start_of_frame (i_start_of_frame),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_full           (full),
        .o_push           (push),
        .o_col            (f_col),
        .o_pix            (f_pix),
        .o_tag            (f_tag)
    );

    sg_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({f_col, f_pix, f_tag}),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata ({b_col, b_pix, b_tag}),
        .o_empty (empty)
    );

    sg_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .o_pop           (pop),
        .i_col           (b_col),
        .i_pix           (b_pix),
        .i_tag           (b_tag),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_gradient      (o_gradient),
        .o_last_of_row   (o_last_of_row),
        .o_last_of_frame (o_last_of_frame),
        .o_status        (status)
    );

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_frame_end_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_frame |-> o_last_of_row)
        else $error("last_of_frame without last_of_row");

    a_no_phantom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty && !status.s1_valid && !status.s2_valid && !o_out_valid |=> !o_out_valid)
        else $error("result with empty pipeline");

    a_grad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_gradient <= PIX_W'(252))
        else $error("gradient out of range");
endmodule
